### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define AVG_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked on every edge, reset included
`define AVG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/avg_pkg.sv
// types, widths and helpers for the arrowhead vertex generator
// no dependencies; used by the core and its checker
package avg_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int SCALE_WIDTH = 16;
    localparam int WING_WIDTH  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int ADDR_WIDTH  = 3;

    localparam int PW   = COORD_WIDTH + SCALE_WIDTH;       // vector * scale
    localparam int SW   = PW - FRAC_BITS;                  // scaled vector, signed
    localparam int TW   = COORD_WIDTH + 9;                 // base + scaled vector
    localparam int MW   = COORD_WIDTH + 7;                 // scaled vector magnitude
    localparam int RW   = (MW > 31) ? 31 : MW;             // direction magnitude
    localparam int SHW  = MW - RW;                         // extra bits to normalize away
    localparam int QSW  = 2 * RW + 1;                      // sum of squares
    localparam int NR   = RW + 1;                          // root bits
    localparam int RAD  = 2 * NR;                          // padded radicand
    localparam int REMW = NR + 2;                          // root remainder
    localparam int AW   = RW + 1;                          // |rx +- ry|
    localparam int WAW  = AW + WING_WIDTH;                 // w * |rx +- ry|
    localparam int NW   = WAW + 1;                         // plus half divisor
    localparam int QW   = 18;                              // wing offset quotient
    localparam int CMPW = (NW > NR + QW) ? NW : NR + QW;
    localparam int FW   = TW + 1;                          // final sums

    localparam logic [WING_WIDTH-1:0]   WING_SIZE_RESET = 16'd1280;
    localparam logic [ADDR_WIDTH-3:0]   REG_WING_SIZE   = '0;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] base_x;
        logic signed [COORD_WIDTH-1:0] base_y;
        logic signed [COORD_WIDTH-1:0] vec_x;
        logic signed [COORD_WIDTH-1:0] vec_y;
        logic        [SCALE_WIDTH-1:0] scale;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] tip_x;
        logic signed [COORD_WIDTH-1:0] tip_y;
        logic signed [COORD_WIDTH-1:0] wing_left_x;
        logic signed [COORD_WIDTH-1:0] wing_left_y;
        logic signed [COORD_WIDTH-1:0] wing_right_x;
        logic signed [COORD_WIDTH-1:0] wing_right_y;
        logic                          degenerate;
    } out_item_t;

    // per-item values that ride along the root and divide stages
    typedef struct packed {
        logic signed [TW-1:0]          tsum_x;
        logic signed [TW-1:0]          tsum_y;
        logic        [COORD_WIDTH-1:0] tip_x;
        logic        [COORD_WIDTH-1:0] tip_y;
        logic                          degenerate;
        logic                          a_neg;
        logic                          b_neg;
    } carry_t;

    function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [FW-1:0] v);
        logic [FW-COORD_WIDTH:0] top;
        top = v[FW-1:COORD_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[FW-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

### rtl/arrowhead_vertex_generator_core.sv
// arrowhead vertex generator core: scaled tip and two rotated wing points per arrow
// depends on avg_pkg
//
// One arrow is taken per clock while the output is not stalled, and one result transfer comes out per arrow, in order.
// The scaled vector s = vec * scale (Q8.8, rounded half away from zero) is added to the
// base to give the tip. The wings are the tip plus the wing offset (-w, +-w) rotated
// into the direction of s, computed as w*(rx +- ry) / |r| with |r| = floor(sqrt(rx^2 +
// ry^2)), each quotient rounded half away from zero. All points saturate to the signed
// coordinate range. A zero scaled vector gives wings equal to the tip and sets
// degenerate. The square root resolves one root bit per stage and the divider one
// quotient bit per stage. Throughput is one transfer per cycle; the whole pipe holds
// while a finished result waits and m_ready is low. wing_size sits at byte address 0
// of the APB port and should be written only while the pipe is empty.
module arrowhead_vertex_generator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  avg_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output avg_pkg::out_item_t                  m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [avg_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CW   = avg_pkg::COORD_WIDTH;
    localparam int PW   = avg_pkg::PW;
    localparam int SW   = avg_pkg::SW;
    localparam int TW   = avg_pkg::TW;
    localparam int MW   = avg_pkg::MW;
    localparam int RW   = avg_pkg::RW;
    localparam int SHW  = avg_pkg::SHW;
    localparam int QSW  = avg_pkg::QSW;
    localparam int NR   = avg_pkg::NR;
    localparam int RAD  = avg_pkg::RAD;
    localparam int REMW = avg_pkg::REMW;
    localparam int AW   = avg_pkg::AW;
    localparam int WAW  = avg_pkg::WAW;
    localparam int NW   = avg_pkg::NW;
    localparam int QW   = avg_pkg::QW;
    localparam int CMPW = avg_pkg::CMPW;
    localparam int FW   = avg_pkg::FW;
    localparam int FB   = avg_pkg::FRAC_BITS;
    localparam int WW   = avg_pkg::WING_WIDTH;
    localparam int AB   = avg_pkg::ADDR_WIDTH;

    // valid bits: p1..p5, root stages 0..NR, divide stages 0..QW
    localparam int NV   = 7 + NR + QW;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    logic [WW-1:0] wing_size_reg;
    logic          cfg_sel;

    assign cfg_sel = (paddr[AB-1:2] == avg_pkg::REG_WING_SIZE);
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? {{(32-WW){1'b0}}, wing_size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wing_size_reg <= avg_pkg::WING_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            wing_size_reg <= pwdata[WW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // flow control: every stage moves together unless the output is stuck
    // ------------------------------------------------------------------
    logic          adv;
    logic [NV-1:0] vld_reg;
    logic          m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NV-2:0], s_valid};
            m_valid_reg <= vld_reg[NV-1];
        end
    end

    // ------------------------------------------------------------------
    // p1: vector times scale
    // ------------------------------------------------------------------
    logic signed [PW:0]   p1_full_next [2];
    logic signed [PW-1:0] p1_prod_reg  [2];
    logic signed [CW-1:0] p1_base_reg  [2];

    always_comb begin
        p1_full_next[0] = $signed(s_data.vec_x) * $signed({1'b0, s_data.scale});
        p1_full_next[1] = $signed(s_data.vec_y) * $signed({1'b0, s_data.scale});
    end

    // ------------------------------------------------------------------
    // p2: drop the Q8.8 fraction, rounding half away from zero
    // ------------------------------------------------------------------
    logic [PW-1:0]        p2_pmag   [2];
    logic [PW-1:0]        p2_rnd    [2];
    logic [SW-1:0]        p2_m      [2];
    logic signed [SW-1:0] p2_s_next [2];
    logic signed [SW-1:0] p2_s_reg  [2];
    logic signed [CW-1:0] p2_base_reg [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            p2_pmag[a]   = p1_prod_reg[a][PW-1] ? PW'(~p1_prod_reg[a] + 1'b1)
                                                : PW'(p1_prod_reg[a]);
            p2_rnd[a]    = p2_pmag[a] + PW'(1 << (FB - 1));
            p2_m[a]      = p2_rnd[a][PW-1:FB];
            p2_s_next[a] = p1_prod_reg[a][PW-1] ? SW'(~p2_m[a] + 1'b1) : p2_m[a];
        end
    end

    // ------------------------------------------------------------------
    // p3: tip sum and saturation, direction magnitudes normalized below 2^31
    // ------------------------------------------------------------------
    logic signed [TW-1:0] p3_tsum_next [2];
    logic [SW-1:0]        p3_smag      [2];
    logic [MW-1:0]        p3_ms        [2];
    logic [RW-1:0]        p3_mr_next   [2];
    avg_pkg::carry_t      p3_cr_next;
    avg_pkg::carry_t      p3_cr_reg;
    logic [RW-1:0]        p3_mag_reg   [2];
    logic                 p3_neg_reg   [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            p3_tsum_next[a] = TW'(p2_base_reg[a]) + TW'(p2_s_reg[a]);
            p3_smag[a]      = p2_s_reg[a][SW-1] ? SW'(~p2_s_reg[a] + 1'b1) : SW'(p2_s_reg[a]);
            p3_ms[a]        = p3_smag[a][MW-1:0];
        end
        p3_cr_next.tsum_x     = p3_tsum_next[0];
        p3_cr_next.tsum_y     = p3_tsum_next[1];
        p3_cr_next.tip_x      = avg_pkg::sat_coord(FW'(p3_tsum_next[0]));
        p3_cr_next.tip_y      = avg_pkg::sat_coord(FW'(p3_tsum_next[1]));
        p3_cr_next.degenerate = (p2_s_reg[0] == '0) && (p2_s_reg[1] == '0);
        p3_cr_next.a_neg      = 1'b0;
        p3_cr_next.b_neg      = 1'b0;
    end

    generate
        if (SHW > 0) begin : g_norm
            localparam int KW = $clog2(SHW + 1);
            logic [SHW-1:0] hi;
            logic [KW-1:0]  k;
            // both components halve together until each is below 2^31
            always_comb begin
                hi = p3_ms[0][MW-1:RW] | p3_ms[1][MW-1:RW];
                k  = '0;
                for (int i = 0; i < SHW; i++) begin
                    if (hi[i]) begin
                        k = KW'(i + 1);
                    end
                end
                p3_mr_next[0] = RW'(p3_ms[0] >> k);
                p3_mr_next[1] = RW'(p3_ms[1] >> k);
            end
        end else begin : g_no_norm
            assign p3_mr_next[0] = RW'(p3_ms[0]);
            assign p3_mr_next[1] = RW'(p3_ms[1]);
        end
    endgenerate

    // ------------------------------------------------------------------
    // p4: squares of the direction, a = rx + ry, b = rx - ry
    // ------------------------------------------------------------------
    logic signed [RW:0]   p4_rs     [2];
    logic [2*RW-1:0]      p4_sq_next [2];
    logic signed [RW+1:0] p4_a_next;
    logic signed [RW+1:0] p4_b_next;
    logic [2*RW-1:0]      p4_sq_reg [2];
    logic signed [RW+1:0] p4_a_reg;
    logic signed [RW+1:0] p4_b_reg;
    avg_pkg::carry_t      p4_cr_reg;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            p4_rs[a]      = p3_neg_reg[a] ? (RW+1)'(~{1'b0, p3_mag_reg[a]} + 1'b1)
                                          : {1'b0, p3_mag_reg[a]};
            p4_sq_next[a] = (2*RW)'(p3_mag_reg[a] * p3_mag_reg[a]);
        end
        p4_a_next = {p4_rs[0][RW], p4_rs[0]} + {p4_rs[1][RW], p4_rs[1]};
        p4_b_next = {p4_rs[0][RW], p4_rs[0]} - {p4_rs[1][RW], p4_rs[1]};
    end

    // ------------------------------------------------------------------
    // p5: sum of squares, magnitudes and signs of a and b
    // ------------------------------------------------------------------
    logic [QSW-1:0]  p5_ssum_next;
    logic [RW+1:0]   p5_amag;
    logic [RW+1:0]   p5_bmag;
    avg_pkg::carry_t p5_cr_next;
    logic [QSW-1:0]  p5_ssum_reg;
    logic [AW-1:0]   p5_amag_reg;
    logic [AW-1:0]   p5_bmag_reg;
    avg_pkg::carry_t p5_cr_reg;

    always_comb begin
        p5_ssum_next     = QSW'(p4_sq_reg[0]) + QSW'(p4_sq_reg[1]);
        p5_amag          = p4_a_reg[RW+1] ? (RW+2)'(~p4_a_reg + 1'b1) : (RW+2)'(p4_a_reg);
        p5_bmag          = p4_b_reg[RW+1] ? (RW+2)'(~p4_b_reg + 1'b1) : (RW+2)'(p4_b_reg);
        p5_cr_next       = p4_cr_reg;
        p5_cr_next.a_neg = p4_a_reg[RW+1];
        p5_cr_next.b_neg = p4_b_reg[RW+1];
    end

    // ------------------------------------------------------------------
    // p6 loads root stage 0: numerators w*|a|, w*|b| and the radicand
    // root stages: one root bit each, restoring digit-by-digit
    // ------------------------------------------------------------------
    logic [RAD-1:0]  sq_rad_reg  [0:NR];
    logic [REMW-1:0] sq_rem_reg  [0:NR];
    logic [NR-1:0]   sq_root_reg [0:NR];
    logic [WAW-1:0]  sq_wa_reg   [0:NR];
    logic [WAW-1:0]  sq_wb_reg   [0:NR];
    avg_pkg::carry_t sq_cr_reg   [0:NR];

    logic [REMW-1:0] sq_remn      [0:NR-1];
    logic [REMW-1:0] sq_trial     [0:NR-1];
    logic [REMW-1:0] sq_rem_next  [0:NR-1];
    logic [NR-1:0]   sq_root_next [0:NR-1];
    logic [RAD-1:0]  sq_rad_next  [0:NR-1];

    always_comb begin
        for (int k = 0; k < NR; k++) begin
            sq_remn[k]     = {sq_rem_reg[k][REMW-3:0], sq_rad_reg[k][RAD-1 -: 2]};
            sq_trial[k]    = {sq_root_reg[k], 2'b01};
            sq_rad_next[k] = {sq_rad_reg[k][RAD-3:0], 2'b00};
            if (sq_remn[k] >= sq_trial[k]) begin
                sq_rem_next[k]  = sq_remn[k] - sq_trial[k];
                sq_root_next[k] = {sq_root_reg[k][NR-2:0], 1'b1};
            end else begin
                sq_rem_next[k]  = sq_remn[k];
                sq_root_next[k] = {sq_root_reg[k][NR-2:0], 1'b0};
            end
        end
    end

    // ------------------------------------------------------------------
    // divide stages: both quotients in parallel, one bit each, msb first
    // stage 0 adds half the divisor for round-half-away
    // ------------------------------------------------------------------
    logic [NW-1:0]   dv_na_reg  [0:QW];
    logic [NW-1:0]   dv_nb_reg  [0:QW];
    logic [NR-1:0]   dv_len_reg [0:QW];
    logic [QW-1:0]   dv_qa_reg  [0:QW];
    logic [QW-1:0]   dv_qb_reg  [0:QW];
    avg_pkg::carry_t dv_cr_reg  [0:QW];

    logic [CMPW-1:0] dv_dsh     [0:QW-1];
    logic [NW-1:0]   dv_na_next [0:QW-1];
    logic [NW-1:0]   dv_nb_next [0:QW-1];
    logic [QW-1:0]   dv_qa_next [0:QW-1];
    logic [QW-1:0]   dv_qb_next [0:QW-1];

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            dv_dsh[j]     = CMPW'(dv_len_reg[j]) << (QW - 1 - j);
            dv_na_next[j] = dv_na_reg[j];
            dv_nb_next[j] = dv_nb_reg[j];
            dv_qa_next[j] = dv_qa_reg[j];
            dv_qb_next[j] = dv_qb_reg[j];
            if (CMPW'(dv_na_reg[j]) >= dv_dsh[j]) begin
                dv_na_next[j]           = NW'(CMPW'(dv_na_reg[j]) - dv_dsh[j]);
                dv_qa_next[j][QW-1-j]   = 1'b1;
            end
            if (CMPW'(dv_nb_reg[j]) >= dv_dsh[j]) begin
                dv_nb_next[j]           = NW'(CMPW'(dv_nb_reg[j]) - dv_dsh[j]);
                dv_qb_next[j][QW-1-j]   = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // last stage: signed offsets added to the unsaturated tip, then saturate
    // left = tip + (-qa, +qb), right = tip + (-qb, -qa)
    // ------------------------------------------------------------------
    avg_pkg::carry_t    fn_cr;
    logic signed [QW:0] fn_qa;
    logic signed [QW:0] fn_qb;
    logic signed [FW-1:0] fn_lx;
    logic signed [FW-1:0] fn_ly;
    logic signed [FW-1:0] fn_rx;
    logic signed [FW-1:0] fn_ry;
    avg_pkg::out_item_t m_data_next;
    avg_pkg::out_item_t m_data_reg;

    always_comb begin
        fn_cr = dv_cr_reg[QW];
        fn_qa = fn_cr.a_neg ? (QW+1)'(~{1'b0, dv_qa_reg[QW]} + 1'b1) : {1'b0, dv_qa_reg[QW]};
        fn_qb = fn_cr.b_neg ? (QW+1)'(~{1'b0, dv_qb_reg[QW]} + 1'b1) : {1'b0, dv_qb_reg[QW]};
        fn_lx = FW'(fn_cr.tsum_x) - FW'(fn_qa);
        fn_ly = FW'(fn_cr.tsum_y) + FW'(fn_qb);
        fn_rx = FW'(fn_cr.tsum_x) - FW'(fn_qb);
        fn_ry = FW'(fn_cr.tsum_y) - FW'(fn_qa);

        m_data_next.tip_x      = fn_cr.tip_x;
        m_data_next.tip_y      = fn_cr.tip_y;
        m_data_next.degenerate = fn_cr.degenerate;
        if (fn_cr.degenerate) begin
            // zero length: wings collapse onto the tip
            m_data_next.wing_left_x  = fn_cr.tip_x;
            m_data_next.wing_left_y  = fn_cr.tip_y;
            m_data_next.wing_right_x = fn_cr.tip_x;
            m_data_next.wing_right_y = fn_cr.tip_y;
        end else begin
            m_data_next.wing_left_x  = avg_pkg::sat_coord(fn_lx);
            m_data_next.wing_left_y  = avg_pkg::sat_coord(fn_ly);
            m_data_next.wing_right_x = avg_pkg::sat_coord(fn_rx);
            m_data_next.wing_right_y = avg_pkg::sat_coord(fn_ry);
        end
    end

    assign m_data = m_data_reg;

    // ------------------------------------------------------------------
    // payload registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            // p1
            p1_prod_reg[0] <= p1_full_next[0][PW-1:0];
            p1_prod_reg[1] <= p1_full_next[1][PW-1:0];
            p1_base_reg[0] <= s_data.base_x;
            p1_base_reg[1] <= s_data.base_y;
            // p2
            p2_s_reg       <= p2_s_next;
            p2_base_reg    <= p1_base_reg;
            // p3
            p3_cr_reg      <= p3_cr_next;
            p3_mag_reg     <= p3_mr_next;
            p3_neg_reg[0]  <= p2_s_reg[0][SW-1];
            p3_neg_reg[1]  <= p2_s_reg[1][SW-1];
            // p4
            p4_sq_reg      <= p4_sq_next;
            p4_a_reg       <= p4_a_next;
            p4_b_reg       <= p4_b_next;
            p4_cr_reg      <= p3_cr_reg;
            // p5
            p5_ssum_reg    <= p5_ssum_next;
            p5_amag_reg    <= p5_amag[AW-1:0];
            p5_bmag_reg    <= p5_bmag[AW-1:0];
            p5_cr_reg      <= p5_cr_next;
            // p6 into root stage 0
            sq_rad_reg[0]  <= RAD'(p5_ssum_reg);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_wa_reg[0]   <= WAW'(p5_amag_reg * wing_size_reg);
            sq_wb_reg[0]   <= WAW'(p5_bmag_reg * wing_size_reg);
            sq_cr_reg[0]   <= p5_cr_reg;
            for (int k = 0; k < NR; k++) begin
                sq_rad_reg[k+1]  <= sq_rad_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_wa_reg[k+1]   <= sq_wa_reg[k];
                sq_wb_reg[k+1]   <= sq_wb_reg[k];
                sq_cr_reg[k+1]   <= sq_cr_reg[k];
            end
            // divide stage 0: length is now known
            dv_na_reg[0]  <= NW'(sq_wa_reg[NR]) + NW'(sq_root_reg[NR] >> 1);
            dv_nb_reg[0]  <= NW'(sq_wb_reg[NR]) + NW'(sq_root_reg[NR] >> 1);
            dv_len_reg[0] <= sq_root_reg[NR];
            dv_qa_reg[0]  <= '0;
            dv_qb_reg[0]  <= '0;
            dv_cr_reg[0]  <= sq_cr_reg[NR];
            for (int j = 0; j < QW; j++) begin
                dv_na_reg[j+1]  <= dv_na_next[j];
                dv_nb_reg[j+1]  <= dv_nb_next[j];
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_qa_reg[j+1]  <= dv_qa_next[j];
                dv_qb_reg[j+1]  <= dv_qb_next[j];
                dv_cr_reg[j+1]  <= dv_cr_reg[j];
            end
            // output register
            m_data_reg <= m_data_next;
        end
    end

endmodule

### rtl/avg_checker.sv
// port-level checks for the arrowhead vertex generator core, bound to the top level
// depends on avg_pkg and assert_macros.svh
`include "assert_macros.svh"

module avg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input avg_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input avg_pkg::out_item_t m_data
);

    // a waiting result holds still
    `AVG_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // input side is open exactly when the output can move
    `AVG_ASSERT(a_ready_link, aclk, aresetn, s_ready == (!m_valid || m_ready), "ready does not follow output stall")

    // a zero-length arrow folds its wings onto the tip
    `AVG_ASSERT(a_degen_wings, aclk, aresetn, m_valid && m_data.degenerate |-> m_data.wing_left_x == m_data.tip_x && m_data.wing_left_y == m_data.tip_y && m_data.wing_right_x == m_data.tip_x && m_data.wing_right_y == m_data.tip_y, "degenerate wings differ from tip")

    // reset empties the output
    `AVG_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind arrowhead_vertex_generator_core avg_checker u_avg_checker (.*);
